>>> design/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// command codes, status codes, cell operations and fixed field widths
// ---------------------------------------------------------------------------
package spq_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // command codes of an input word
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2
    } t_cmd;

    // status codes of a result word
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } t_cell_op;

    // per-cell control from the queue controller
    typedef struct packed {
        t_cell_op op;
        logic     occupied;
    } t_cell_ctrl;

endpackage

>>> design/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue, highest priority first
// a row of DEPTH cells kept in order, front in cell zero
// ---------------------------------------------------------------------------
// usage
//   a command word is taken at a rising edge with start high and busy low;
//   busy stays low, so a new command can be given in every cycle
//   commands: enqueue (data, priority), dequeue front, peek front
//   every command gives one registered result word, in the cycle after it is taken,
//   shown for exactly one cycle with o_valid high
//   result: front data (zero unless dequeue/peek succeeds), status
//   (ok, empty, full) and occupancy after the command
//   throughput 1 command per cycle: all cells compare
//   against the new priority in parallel and shift in the same edge
//   equal priorities leave last-in-first-out; enqueue when full is dropped
//   the receiver cannot stall; results are not held
//   reset (synchronous, active low) empties the queue and clears o_valid;
//   cell contents are not cleared, only the entry count
// ---------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           i_command,
    input  logic signed [DATA_W-1:0]   i_item_data,
    input  logic signed [PRIO_W-1:0]   i_item_priority,
    output logic                       o_valid,
    output logic signed [DATA_W-1:0]   o_front_data,
    output logic [STATUS_W-1:0]        o_status,
    output logic [OCC_W-1:0]           o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    logic signed [DATA_W-1:0] r_front_data;
    logic signed [DATA_W-1:0] n_front_data;
    t_status                  r_status;
    t_status                  n_status;
    t_cell_op                 n_op;
    logic                     w_accept;
    logic [CNT_W+OCC_W-1:0]   w_occ_ext;

    logic signed [DATA_W-1:0] w_data  [DEPTH];
    logic signed [PRIO_W-1:0] w_prio  [DEPTH];
    logic                     w_stays [DEPTH];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // command decode and result word
    always_comb begin
        n_op         = OP_HOLD;
        n_status     = ST_OK;
        n_front_data = '0;
        n_count      = r_count;
        if (w_accept) begin
            unique case (t_cmd'(i_command))
                CMD_ENQUEUE: begin
                    if (r_count == CNT_W'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_op    = OP_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_DEQUEUE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_op         = OP_REMOVE;
                        n_front_data = w_data[0];
                        n_count      = r_count - 1'b1;
                    end
                end
                CMD_PEEK: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_front_data = w_data[0];
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctrl               w_ctrl;
        logic                     w_prev_stays;
        logic signed [DATA_W-1:0] w_prev_data;
        logic signed [PRIO_W-1:0] w_prev_prio;
        logic signed [DATA_W-1:0] w_next_data;
        logic signed [PRIO_W-1:0] w_next_prio;

        assign w_ctrl.op       = n_op;
        assign w_ctrl.occupied = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign w_prev_stays = 1'b1;
            assign w_prev_data  = i_item_data;
            assign w_prev_prio  = i_item_priority;
        end else begin : g_inner
            assign w_prev_stays = w_stays[g-1];
            assign w_prev_data  = w_data[g-1];
            assign w_prev_prio  = w_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_data = w_data[g];
            assign w_next_prio = w_prio[g];
        end else begin : g_body
            assign w_next_data = w_data[g+1];
            assign w_next_prio = w_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_new_data   (i_item_data),
            .i_new_prio   (i_item_priority),
            .i_prev_stays (w_prev_stays),
            .i_prev_data  (w_prev_data),
            .i_prev_prio  (w_prev_prio),
            .i_next_data  (w_next_data),
            .i_next_prio  (w_next_prio),
            .o_stays      (w_stays[g]),
            .o_data       (w_data[g]),
            .o_prio       (w_prio[g])
        );
    end

    // entry count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        r_front_data <= n_front_data;
        r_status     <= n_status;
    end

    assign w_occ_ext    = {{OCC_W{1'b0}}, r_count};
    assign o_valid      = r_valid;
    assign o_front_data = r_front_data;
    assign o_status     = r_status;
    assign o_occupancy  = w_occ_ext[OCC_W-1:0];

    // count never passes the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // a successful dequeue removes exactly one entry
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_DEQUEUE && r_count != '0)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not lower the count by one");

    // one result word for each accepted command word
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted command gave no result word");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_valid)
        else $error("result word without a command");

    // front cells stay in priority order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_prio[0] >= w_prio[1]))
        else $error("front entries out of order");

    // empty status carries zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_front_data == '0))
        else $error("empty result with nonzero data");

endmodule

>>> design/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// holds one entry, compares it to the incoming priority, and takes its
// neighbor's entry when the row shifts
// ---------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_new_data,
    input  logic signed [PRIO_W-1:0] i_new_prio,
    input  logic                     i_prev_stays,
    input  logic signed [DATA_W-1:0] i_prev_data,
    input  logic signed [PRIO_W-1:0] i_prev_prio,
    input  logic signed [DATA_W-1:0] i_next_data,
    input  logic signed [PRIO_W-1:0] i_next_prio,
    output logic                     o_stays,
    output logic signed [DATA_W-1:0] o_data,
    output logic signed [PRIO_W-1:0] o_prio
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [PRIO_W-1:0] r_prio;
    logic signed [DATA_W-1:0] n_data;
    logic signed [PRIO_W-1:0] n_prio;

    // an occupied entry keeps its place when strictly higher than the new one
    assign o_stays = i_ctrl.occupied && (r_prio > i_new_prio);

    // next entry for this slot
    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        unique case (i_ctrl.op)
            OP_INSERT: begin
                priority if (o_stays) begin
                    n_data = r_data;
                    n_prio = r_prio;
                end else if (i_prev_stays) begin
                    n_data = i_new_data;
                    n_prio = i_new_prio;
                end else begin
                    n_data = i_prev_data;
                    n_prio = i_prev_prio;
                end
            end
            OP_REMOVE: begin
                n_data = i_next_data;
                n_prio = i_next_prio;
            end
            default: begin
                n_data = r_data;
                n_prio = r_prio;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted priority queue
// a negedge driver feeds command words from a pending queue with random
// gaps; a posedge monitor predicts every accepted word with a local copy
// of the ordered entry list and checks each result word field by field
// ---------------------------------------------------------------------------
module tb_top;
    import spq_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_WORDS = 525;
    localparam int PRINT_CAP    = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'sh7fffffff;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 32'sh80000000;

    // one command word as presented to the block
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [DATA_W-1:0]  data;
        logic signed [PRIO_W-1:0]  prio;
        logic                      drain_first;
    } t_command_word;

    // one result word as the block should show it
    typedef struct packed {
        logic signed [DATA_W-1:0]  front_data;
        logic [STATUS_W-1:0]       status;
        logic [OCC_W-1:0]          occupancy;
    } t_result_word;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          i_command;
    logic signed [DATA_W-1:0]  i_item_data;
    logic signed [PRIO_W-1:0]  i_item_priority;
    logic                      o_valid;
    logic signed [DATA_W-1:0]  o_front_data;
    logic [STATUS_W-1:0]       o_status;
    logic [OCC_W-1:0]          o_occupancy;

    // stimulus and scoreboard storage
    t_command_word commands_pending[$];
    t_result_word  results_due[$];
    t_command_word current_word;

    // local copy of the ordered entry list, front at index zero
    logic signed [DATA_W-1:0]  held_data [QDEPTH];
    logic signed [PRIO_W-1:0]  held_prio [QDEPTH];
    int                        held_count = 0;

    // driver and monitor handshake bookkeeping
    bit presenting = 1'b0;
    bit word_taken = 1'b0;
    int gap_left = 0;
    int steady_left = 0;

    // counters
    int mismatch_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int enq_ok = 0;
    int enq_full = 0;
    int deq_ok = 0;
    int peek_ok = 0;
    int empty_reads = 0;
    int unused_codes = 0;
    int deepest = 0;
    int drain_pauses = 0;

    sorted_priority_queue #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .o_valid         (o_valid),
        .o_front_data    (o_front_data),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(CLK_PERIOD * 250_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // apply one command to the local entry list and return its result word
    function automatic t_result_word predict_front_result(input t_command_word w);
        t_result_word r;
        int pos;
        r.front_data = '0;
        r.status     = ST_OK;
        case (w.cmd)
            CMD_ENQUEUE: begin
                if (held_count >= QDEPTH) begin
                    r.status = ST_FULL;
                    enq_full++;
                end else begin
                    // behind every strictly higher priority, ahead of equal ones
                    pos = 0;
                    while (pos < held_count && $signed(held_prio[pos]) > $signed(w.prio))
                        pos++;
                    for (int i = held_count; i > pos; i--) begin
                        held_data[i] = held_data[i-1];
                        held_prio[i] = held_prio[i-1];
                    end
                    held_data[pos] = w.data;
                    held_prio[pos] = w.prio;
                    held_count++;
                    enq_ok++;
                    if (held_count > deepest) deepest = held_count;
                end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                    empty_reads++;
                end else begin
                    r.front_data = held_data[0];
                    if (w.cmd == CMD_DEQUEUE) begin
                        for (int i = 0; i + 1 < held_count; i++) begin
                            held_data[i] = held_data[i+1];
                            held_prio[i] = held_prio[i+1];
                        end
                        held_count--;
                        deq_ok++;
                    end else begin
                        peek_ok++;
                    end
                end
            end
            default: unused_codes++;
        endcase
        r.occupancy = OCC_W'(held_count);
        return r;
    endfunction

    // gap after a word: mostly none or short, a few long, some steady runs
    function automatic int pick_gap();
        int r;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return PRIO_MAX;
            1:       return PRIO_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // narrow ranges give many equal priorities, so the lifo rule is hit often
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return PRIO_W'($urandom_range(0, 8) - 4);
        if (r < 6) return pick_extreme();
        return $urandom;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_data();
        if ($urandom_range(0, 9) == 0) return pick_extreme();
        return $urandom;
    endfunction

    task automatic add_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] data,
                               input logic signed [PRIO_W-1:0] prio,
                               input logic drain_first);
        t_command_word w;
        w.cmd         = cmd;
        w.data        = data;
        w.prio        = prio;
        w.drain_first = drain_first;
        commands_pending.push_back(w);
    endtask

    // driver: new word or idle values at the falling edge
    always @(negedge i_clk) begin : command_driver
        if (i_rst_n) begin
            if (presenting && word_taken) begin
                presenting = 1'b0;
                words_sent++;
                gap_left = pick_gap();
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (commands_pending.size() > 0) begin
                    if (!(commands_pending[0].drain_first && results_due.size() != 0)) begin
                        current_word = commands_pending.pop_front();
                        presenting = 1'b1;
                        if (current_word.drain_first) drain_pauses++;
                    end
                end
            end
            if (presenting) begin
                start           <= 1'b1;
                i_command       <= current_word.cmd;
                i_item_data     <= current_word.data;
                i_item_priority <= current_word.prio;
            end else begin
                start           <= 1'b0;
                i_command       <= CMD_W'($urandom);
                i_item_data     <= $urandom;
                i_item_priority <= $urandom;
            end
        end
    end

    // monitor: check the result word, then predict the word taken this edge
    always @(posedge i_clk) begin : result_monitor
        t_result_word due;
        t_command_word seen;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                if (o_valid !== 1'b1) begin
                    report_mismatch("o_valid is unknown");
                end else if (results_due.size() == 0) begin
                    report_mismatch("result word with nothing due");
                end else begin
                    due = results_due.pop_front();
                    results_seen++;
                    if (o_front_data !== due.front_data)
                        report_mismatch($sformatf("front_data %h, due %h",
                                                  o_front_data, due.front_data));
                    if (o_status !== due.status)
                        report_mismatch($sformatf("status %0d, due %0d",
                                                  o_status, due.status));
                    if (o_occupancy !== due.occupancy)
                        report_mismatch($sformatf("occupancy %0d, due %0d",
                                                  o_occupancy, due.occupancy));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                word_taken       = 1'b1;
                seen.cmd         = i_command;
                seen.data        = i_item_data;
                seen.prio        = i_item_priority;
                seen.drain_first = 1'b0;
                results_due.push_back(predict_front_result(seen));
            end
        end
    end

    // reset, stimulus and end of run
    initial begin
        int fill_bias;
        logic [CMD_W-1:0] cmd;

        start           = 1'b0;
        i_command       = CMD_ENQUEUE;
        i_item_data     = '0;
        i_item_priority = '0;
        i_rst_n         = 1'b0;

        // empty queue reads and an unused code
        add_command(CMD_DEQUEUE, 32'h12345678, PRIO_MAX, 1'b0);
        add_command(CMD_PEEK, '1, PRIO_MIN, 1'b0);
        add_command(CMD_UNUSED, 32'h5a5a5a5a, 32'sh1, 1'b0);

        // fill to the brim with extremes and equal priorities
        add_command(CMD_ENQUEUE, 32'sh7fffffff, '0, 1'b0);
        add_command(CMD_ENQUEUE, 32'sh80000000, '0, 1'b0);
        add_command(CMD_ENQUEUE, '0, PRIO_MAX, 1'b0);
        add_command(CMD_ENQUEUE, '1, PRIO_MIN, 1'b0);
        add_command(CMD_ENQUEUE, 32'sd5, PRIO_MIN, 1'b0);
        add_command(CMD_ENQUEUE, 32'sd6, PRIO_MAX, 1'b0);
        for (int i = 0; i < 10; i++)
            add_command(CMD_ENQUEUE, DATA_W'(100 + i), PRIO_W'((i % 3) - 1), 1'b0);

        // enqueue into a full queue, sent only after everything has drained
        add_command(CMD_ENQUEUE, 32'h55555555, PRIO_MAX, 1'b1);
        add_command(CMD_PEEK, '0, '0, 1'b0);
        add_command(CMD_UNUSED, '1, '1, 1'b0);
        add_command(CMD_DEQUEUE, '0, '0, 1'b0);
        add_command(CMD_DEQUEUE, '0, '0, 1'b0);

        // random traffic, with the enqueue share swinging between phases
        fill_bias = 50;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 40 == 0) fill_bias = $urandom_range(5, 95);
            if ($urandom_range(0, 99) < 3)
                cmd = CMD_UNUSED;
            else if ($urandom_range(0, 99) < fill_bias)
                cmd = CMD_ENQUEUE;
            else if ($urandom_range(0, 3) == 0)
                cmd = CMD_PEEK;
            else
                cmd = CMD_DEQUEUE;
            add_command(cmd, pick_data(), pick_priority(), (n % 150) == 75);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (commands_pending.size() != 0 || presenting || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d words, %0d results: %0d enqueues, %0d dropped full,",
                 words_sent, results_seen, enq_ok, enq_full);
        $display("%0d dequeues, %0d peeks, %0d empty reads, %0d unused codes, depth %0d, %0d drains",
                 deq_ok, peek_ok, empty_reads, unused_codes, deepest, drain_pauses);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
verif/tb_top.sv
